// File: hdl/frac_red_pkg.sv
// Shared types and constants for the fraction reducer.
package frac_red_pkg;

    localparam int DataW   = 32;               // signed numerator/denominator width
    localparam int MagW    = DataW - 1;        // magnitude width after saturation
    localparam int CntW    = $clog2(MagW + 1); // step counter, can hold MagW itself
    localparam int TdataW  = ((DataW + DataW + 7) / 8) * 8;
    localparam int OutW    = ((DataW + MagW + 7) / 8) * 8;

    localparam logic [CntW-1:0] DivSteps = CntW'(MagW);

    // Controller to datapath commands.
    typedef struct packed {
        logic load;          // capture input magnitudes and sign
        logic gcd_step;      // one binary GCD step
        logic div_load_num;  // latch divisor, start dividing numerator
        logic div_load_den;  // start dividing denominator, keep divisor
        logic div_step;      // one restoring division step
        logic store_num;     // keep quotient as reduced numerator
        logic store_den;     // keep quotient as reduced denominator
        logic out_load;      // load the output register
    } frac_red_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic any_zero;      // numerator or denominator magnitude is zero
        logic gcd_done;      // both GCD operands odd and equal
        logic div_done;      // all division steps taken
        logic out_free;      // output register empty or draining this cycle
    } frac_red_stat_t;

endpackage

// File: hdl/fraction_reducer.sv
// Top level of the fraction reducer: streaming ports around controller and datapath.
//
// Usage: present a signed fraction on the slave channel (s_tdata: numerator in
// bits 31:0, denominator in bits 63:32, both two's complement). One transaction
// on the master channel returns the fraction in lowest terms, with a
// non-negative denominator. A zero numerator or denominator passes through
// sign-normalized but unreduced; -2^31 is saturated to -(2^31-1).
// Sequence: one load, then the binary GCD (one step per cycle, until both
// operands are odd and equal), then two 31-step restoring divisions sharing
// one divider, then the write of the output register. Zero operands skip the
// GCD and the divisions. One fraction is in work at a time; s_tready is high
// only when the block is free, so a new fraction is accepted only after the
// previous one has been written to the output register.
// The result sits in an output register, so a new fraction is accepted while
// the previous result still waits; a stalled receiver stalls the block only
// when the next result is ready and the register is still full.
// Reset (aresetn low, synchronous) returns to idle and drops any pending result.
module fraction_reducer
    import frac_red_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TdataW-1:0] s_tdata,   // [31:0] numerator, [63:32] denominator
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OutW-1:0]   m_tdata    // [31:0] reduced_numerator,
                                         // [62:32] reduced_denominator, [63] zero
);

    frac_red_cmd_t  cmd;
    frac_red_stat_t stat;

    // Sequence the work for one fraction at a time.
    frac_red_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold magnitudes, run GCD and divisions, drive the result register.
    frac_red_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: hdl/frac_red_dp.sv
// Datapath: sign handling, binary GCD, shared restoring divider, output register.
module frac_red_dp
    import frac_red_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [TdataW-1:0]   s_tdata,
    input  frac_red_cmd_t       cmd,
    output frac_red_stat_t      stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutW-1:0]     m_tdata
);

    logic [DataW-1:0] in_num, in_den;
    logic [DataW-1:0] num_abs, den_abs;
    logic [MagW-1:0]  num_mag, den_mag;

    logic [MagW-1:0]  nmag_reg, dmag_reg;
    logic             neg_reg;
    logic [MagW-1:0]  a_reg, b_reg, a_next, b_next;
    logic [CntW-1:0]  k_reg, k_next;
    logic [MagW-1:0]  divisor_reg;
    logic [MagW-1:0]  rem_reg, rem_next;
    logic [MagW-1:0]  quo_reg, quo_next;
    logic [CntW-1:0]  div_cnt_reg;
    logic [MagW-1:0]  res_num_reg, res_den_reg;
    logic [DataW-1:0] out_num_reg;
    logic [MagW-1:0]  out_den_reg;
    logic             out_valid_reg;

    logic [DataW-1:0] trial, trial_diff;
    logic [DataW-1:0] res_num_ext;

    assign in_num  = s_tdata[DataW-1:0];
    assign in_den  = s_tdata[2*DataW-1:DataW];
    assign num_abs = in_num[DataW-1] ? (~in_num + DataW'(1)) : in_num;
    assign den_abs = in_den[DataW-1] ? (~in_den + DataW'(1)) : in_den;
    // Saturate the most negative value to the largest magnitude.
    assign num_mag = num_abs[DataW-1] ? {MagW{1'b1}} : num_abs[MagW-1:0];
    assign den_mag = den_abs[DataW-1] ? {MagW{1'b1}} : den_abs[MagW-1:0];

    // Binary GCD step.
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (!a_reg[0] && !b_reg[0]) begin
            a_next = a_reg >> 1;
            b_next = b_reg >> 1;
            k_next = k_reg + CntW'(1);
        end else if (!a_reg[0]) begin
            a_next = a_reg >> 1;
        end else if (!b_reg[0]) begin
            b_next = b_reg >> 1;
        end else if (a_reg > b_reg) begin
            a_next = (a_reg - b_reg) >> 1;
        end else begin
            b_next = (b_reg - a_reg) >> 1;
        end
    end

    // Restoring division step: shift one dividend bit into the remainder.
    always_comb begin
        trial      = {rem_reg, quo_reg[MagW-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        if (!trial_diff[DataW-1]) begin
            rem_next = trial_diff[MagW-1:0];
            quo_next = {quo_reg[MagW-2:0], 1'b1};
        end else begin
            rem_next = trial[MagW-1:0];
            quo_next = {quo_reg[MagW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            nmag_reg    <= num_mag;
            dmag_reg    <= den_mag;
            neg_reg     <= in_num[DataW-1] ^ in_den[DataW-1];
            a_reg       <= num_mag;
            b_reg       <= den_mag;
            k_reg       <= '0;
            res_num_reg <= num_mag;
            res_den_reg <= den_mag;
        end else if (cmd.gcd_step) begin
            a_reg <= a_next;
            b_reg <= b_next;
            k_reg <= k_next;
        end
        if (cmd.div_load_num) begin
            divisor_reg <= MagW'(a_reg << k_reg);
            rem_reg     <= '0;
            quo_reg     <= nmag_reg;
            div_cnt_reg <= '0;
        end else if (cmd.div_load_den) begin
            rem_reg     <= '0;
            quo_reg     <= dmag_reg;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            div_cnt_reg <= div_cnt_reg + CntW'(1);
        end
        if (cmd.store_num) begin
            res_num_reg <= quo_reg;
        end
        if (cmd.store_den) begin
            res_den_reg <= quo_reg;
        end
    end

    assign res_num_ext = {1'b0, res_num_reg};

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_num_reg <= (neg_reg && res_num_reg != '0) ? (DataW'(0) - res_num_ext)
                                                          : res_num_ext;
            out_den_reg <= res_den_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.any_zero = (nmag_reg == '0) || (dmag_reg == '0);
    assign stat.gcd_done = a_reg[0] && b_reg[0] && (a_reg == b_reg);
    assign stat.div_done = (div_cnt_reg == DivSteps);
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutW - DataW - MagW){1'b0}}, out_den_reg, out_num_reg};

    // The GCD divides both magnitudes exactly.
    a_exact_num: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_num |-> rem_reg == '0) else $error("numerator not divisible by gcd");
    a_exact_den: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store_den |-> rem_reg == '0) else $error("denominator not divisible by gcd");
    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.gcd_step |-> (a_reg != '0 && b_reg != '0)) else $error("gcd operand zero");
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> div_cnt_reg != DivSteps) else $error("division overran");

endmodule

// File: hdl/frac_red_ctrl.sv
// Controller: sequences load, GCD, two divisions and the output write.
module frac_red_ctrl
    import frac_red_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  frac_red_stat_t stat,
    output frac_red_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIVN = 3'd2;
    localparam logic [2:0] ST_DIVD = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (stat.any_zero) begin
                    state_next = ST_FIN;
                end else if (stat.gcd_done) begin
                    cmd.div_load_num = 1'b1;
                    state_next       = ST_DIVN;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIVN: begin
                if (stat.div_done) begin
                    cmd.store_num    = 1'b1;
                    cmd.div_load_den = 1'b1;
                    state_next       = ST_DIVD;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_DIVD: begin
                if (stat.div_done) begin
                    cmd.store_den = 1'b1;
                    state_next    = ST_FIN;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free) else $error("output overwritten");
    a_zero_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GCD && stat.any_zero) |=> state_reg == ST_FIN)
        else $error("zero operand not bypassed");
    a_accept_gcd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == ST_GCD) else $error("load lost");

endmodule
